### rtl/psm_pkg.sv
package psm_pkg;

  localparam int FRAC_BITS = 16;

  localparam int ACC_W = 66;
  localparam int NUM_W = 31 + FRAC_BITS;
  localparam int QUO_W = FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(QUO_W + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int REG_LIGHT_X = 0;
  localparam int REG_LIGHT_Y = 1;
  localparam int REG_LIGHT_Z = 2;
  localparam int REG_LIGHT_W = 3;

  localparam logic signed [31:0] LIGHT_X_RST = 32'sd0;
  localparam logic signed [31:0] LIGHT_Y_RST = 32'sd0;
  localparam logic signed [31:0] LIGHT_Z_RST = 32'(10 << FRAC_BITS);
  localparam logic signed [31:0] LIGHT_W_RST = 32'(1 << FRAC_BITS);

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sh7fffffff);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sh80000000);

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    fix_t ax;
    fix_t ay;
    fix_t az;
    fix_t bx;
    fix_t by;
    fix_t bz;
    fix_t px;
    fix_t py;
    fix_t pz;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CROSS,
    S_MAG,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DLOAD,
    S_DIV,
    S_DOFF,
    S_DOT,
    S_COL,
    S_EMIT
  } bstate_t;

  function automatic fix_t rsat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    t = (x + ACC_HALF) >>> FRAC_BITS;
    if (t > ACC_MAX) begin
      return 32'sh7fffffff;
    end else if (t < ACC_MIN) begin
      return 32'sh80000000;
    end
    return t[31:0];
  endfunction

endpackage

### rtl/psm_queue.sv
module psm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psm_pkg::item_t  wr_item,
  input  logic            pop,
  output psm_pkg::item_t  head,
  output logic            empty,
  output logic            full
);

  psm_pkg::item_t mem [psm_pkg::QDEPTH];
  logic [psm_pkg::QPTR_W-1:0] wr_ptr;
  logic [psm_pkg::QPTR_W-1:0] rd_ptr;
  logic [psm_pkg::QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full = (count == psm_pkg::QCNT_W'(psm_pkg::QDEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/psm_front.sv
module psm_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic signed [31:0] p0_x,
  input  logic signed [31:0] p0_y,
  input  logic signed [31:0] p0_z,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p1_z,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] p2_z,
  input  logic            q_full,
  output logic            push,
  output psm_pkg::item_t  item
);

  logic signed [32:0] da [3];
  logic signed [32:0] db [3];
  logic [32:0] ma [3];
  logic [32:0] mb [3];
  logic [31:0] sa [3];
  logic [31:0] sb [3];
  logic over_a;
  logic over_b;

  assign in_ready = !q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    da[0] = {p0_x[31], p0_x} - {p1_x[31], p1_x};
    da[1] = {p0_y[31], p0_y} - {p1_y[31], p1_y};
    da[2] = {p0_z[31], p0_z} - {p1_z[31], p1_z};
    db[0] = {p1_x[31], p1_x} - {p2_x[31], p2_x};
    db[1] = {p1_y[31], p1_y} - {p2_y[31], p2_y};
    db[2] = {p1_z[31], p1_z} - {p2_z[31], p2_z};
    over_a = 1'b0;
    over_b = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ma[i] = da[i][32] ? 33'(-da[i]) : 33'(da[i]);
      mb[i] = db[i][32] ? 33'(-db[i]) : 33'(db[i]);
      over_a = over_a | ma[i][32] | ma[i][31];
      over_b = over_b | mb[i][32] | mb[i][31];
    end
    for (int i = 0; i < 3; i++) begin
      sa[i] = over_a ? ma[i][32:1] : ma[i][31:0];
      sb[i] = over_b ? mb[i][32:1] : mb[i][31:0];
      sa[i] = da[i][32] ? -sa[i] : sa[i];
      sb[i] = db[i][32] ? -sb[i] : sb[i];
    end
    item.ax = sa[0];
    item.ay = sa[1];
    item.az = sa[2];
    item.bx = sb[0];
    item.by = sb[1];
    item.bz = sb[2];
    item.px = p2_x;
    item.py = p2_y;
    item.pz = p2_z;
  end

endmodule

### rtl/psm_back.sv
module psm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  psm_pkg::item_t    head,
  output logic              pop,
  input  logic signed [31:0] light_x,
  input  logic signed [31:0] light_y,
  input  logic signed [31:0] light_z,
  input  logic signed [31:0] light_w,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        column,
  output logic signed [31:0] m_row0,
  output logic signed [31:0] m_row1,
  output logic signed [31:0] m_row2,
  output logic signed [31:0] m_row3,
  output logic              last
);

  psm_pkg::bstate_t state;
  psm_pkg::bstate_t state_next;

  psm_pkg::fix_t av [3];
  psm_pkg::fix_t bv [3];
  psm_pkg::fix_t pv [3];
  psm_pkg::fix_t plane [4];
  psm_pkg::fix_t light [4];
  psm_pkg::fix_t rows [4];
  psm_pkg::fix_t dot;
  logic signed [64:0] cacc [3];
  logic [63:0] cm [3];
  logic cs [3];
  logic [63:0] sum;
  logic [63:0] sx;
  logic [63:0] sr;
  logic [63:0] sb;
  logic [63:0] st;
  logic [31:0] len;
  logic [32:0] rem;
  logic [32:0] rem2;
  logic [psm_pkg::QUO_W-1:0] dnum;
  logic [psm_pkg::QUO_W-1:0] quo;
  logic [psm_pkg::QUO_W-1:0] quo_next;
  logic [psm_pkg::NUM_W-1:0] num;
  logic [31:0] qz;
  logic [psm_pkg::DCNT_W-1:0] dcnt;
  logic signed [psm_pkg::ACC_W-1:0] acc;
  logic signed [psm_pkg::ACC_W-1:0] pe;
  logic signed [psm_pkg::ACC_W-1:0] diag;
  logic signed [63:0] prod;
  psm_pkg::fix_t mul_a;
  psm_pkg::fix_t mul_b;
  logic [2:0] k;
  logic phase;
  logic [1:0] row;
  logic [1:0] col;
  logic emit;

  assign light[0] = light_x;
  assign light[1] = light_y;
  assign light[2] = light_z;
  assign light[3] = light_w;
  assign len = (sr == '0) ? 32'd1 : sr[31:0];
  assign pe = {{(psm_pkg::ACC_W-64){prod[63]}}, prod};
  assign diag = {{(psm_pkg::ACC_W-32){dot[31]}}, dot} <<< psm_pkg::FRAC_BITS;
  assign st = sr + sb;
  assign num = {cm[k[1:0]][29:0], {psm_pkg::FRAC_BITS{1'b0}}}
             + {{(psm_pkg::NUM_W-31){1'b0}}, len[31:1]};
  assign rem2 = {rem[31:0], dnum[psm_pkg::QUO_W-1]};
  assign quo_next = {quo[psm_pkg::QUO_W-2:0], (rem2 >= {1'b0, len})};
  assign qz = {{(32-psm_pkg::QUO_W){1'b0}}, quo_next};
  assign emit = (state == psm_pkg::S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      psm_pkg::S_CROSS: begin
        case (k)
          3'd0: begin mul_a = av[1]; mul_b = bv[2]; end
          3'd1: begin mul_a = av[2]; mul_b = bv[1]; end
          3'd2: begin mul_a = av[2]; mul_b = bv[0]; end
          3'd3: begin mul_a = av[0]; mul_b = bv[2]; end
          3'd4: begin mul_a = av[0]; mul_b = bv[1]; end
          default: begin mul_a = av[1]; mul_b = bv[0]; end
        endcase
      end
      psm_pkg::S_SQ: begin
        mul_a = {2'b00, cm[k[1:0]][29:0]};
        mul_b = {2'b00, cm[k[1:0]][29:0]};
      end
      psm_pkg::S_DOFF: begin
        mul_a = plane[k[1:0]];
        mul_b = pv[k[1:0]];
      end
      psm_pkg::S_DOT: begin
        mul_a = plane[k[1:0]];
        mul_b = light[k[1:0]];
      end
      psm_pkg::S_COL: begin
        mul_a = plane[row];
        mul_b = light[col];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      psm_pkg::S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          state_next = psm_pkg::S_CROSS;
        end
      end
      psm_pkg::S_CROSS: begin
        if (phase && k == 3'd5) begin
          state_next = psm_pkg::S_MAG;
        end
      end
      psm_pkg::S_MAG: state_next = psm_pkg::S_NORM;
      psm_pkg::S_NORM: begin
        if (((cm[0] | cm[1] | cm[2]) >> 30) == '0) begin
          state_next = psm_pkg::S_SQ;
        end
      end
      psm_pkg::S_SQ: begin
        if (phase && k == 3'd2) begin
          state_next = psm_pkg::S_SQRT;
        end
      end
      psm_pkg::S_SQRT: begin
        if (sb == 64'd1) begin
          state_next = psm_pkg::S_DLOAD;
        end
      end
      psm_pkg::S_DLOAD: state_next = psm_pkg::S_DIV;
      psm_pkg::S_DIV: begin
        if (dcnt == psm_pkg::DCNT_W'(psm_pkg::QUO_W - 1)) begin
          state_next = (k == 3'd2) ? psm_pkg::S_DOFF : psm_pkg::S_DLOAD;
        end
      end
      psm_pkg::S_DOFF: begin
        if (phase && k == 3'd2) begin
          state_next = psm_pkg::S_DOT;
        end
      end
      psm_pkg::S_DOT: begin
        if (phase && k == 3'd3) begin
          state_next = psm_pkg::S_COL;
        end
      end
      psm_pkg::S_COL: begin
        if (phase && row == 2'd3) begin
          state_next = psm_pkg::S_EMIT;
        end
      end
      psm_pkg::S_EMIT: begin
        if (emit) begin
          state_next = (col == 2'd3) ? psm_pkg::S_IDLE : psm_pkg::S_COL;
        end
      end
      default: state_next = psm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (emit) begin
      column <= col;
      last <= (col == 2'd3);
      m_row0 <= rows[0];
      m_row1 <= rows[1];
      m_row2 <= rows[2];
      m_row3 <= rows[3];
    end
    case (state)
      psm_pkg::S_IDLE: begin
        av[0] <= head.ax;
        av[1] <= head.ay;
        av[2] <= head.az;
        bv[0] <= head.bx;
        bv[1] <= head.by;
        bv[2] <= head.bz;
        pv[0] <= head.px;
        pv[1] <= head.py;
        pv[2] <= head.pz;
        for (int i = 0; i < 3; i++) begin
          cacc[i] <= '0;
        end
        k <= '0;
        phase <= 1'b0;
      end
      psm_pkg::S_CROSS: begin
        phase <= !phase;
        if (phase) begin
          if (k[0]) begin
            cacc[k[2:1]] <= cacc[k[2:1]] - {prod[63], prod};
          end else begin
            cacc[k[2:1]] <= cacc[k[2:1]] + {prod[63], prod};
          end
          k <= k + 3'd1;
        end
      end
      psm_pkg::S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          cs[i] <= cacc[i][64];
          cm[i] <= cacc[i][64] ? 64'(-cacc[i]) : cacc[i][63:0];
        end
        k <= '0;
        phase <= 1'b0;
        sum <= '0;
      end
      psm_pkg::S_NORM: begin
        if (((cm[0] | cm[1] | cm[2]) >> 30) != '0) begin
          for (int i = 0; i < 3; i++) begin
            cm[i] <= cm[i] >> 1;
          end
        end
      end
      psm_pkg::S_SQ: begin
        phase <= !phase;
        if (phase) begin
          sum <= sum + prod;
          k <= k + 3'd1;
          sx <= sum + prod;
          sr <= '0;
          sb <= 64'd1 << 62;
        end
      end
      psm_pkg::S_SQRT: begin
        if (sx >= st) begin
          sx <= sx - st;
          sr <= (sr >> 1) + sb;
        end else begin
          sr <= sr >> 1;
        end
        sb <= sb >> 2;
        k <= '0;
      end
      psm_pkg::S_DLOAD: begin
        rem <= 33'(num >> psm_pkg::QUO_W);
        dnum <= num[psm_pkg::QUO_W-1:0];
        quo <= '0;
        dcnt <= '0;
      end
      psm_pkg::S_DIV: begin
        rem <= (rem2 >= {1'b0, len}) ? rem2 - {1'b0, len} : rem2;
        quo <= quo_next;
        dnum <= dnum << 1;
        dcnt <= dcnt + 1'b1;
        if (dcnt == psm_pkg::DCNT_W'(psm_pkg::QUO_W - 1)) begin
          plane[k[1:0]] <= cs[k[1:0]] ? -qz : qz;
          k <= (k == 3'd2) ? 3'd0 : k + 3'd1;
          phase <= 1'b0;
          acc <= '0;
        end
      end
      psm_pkg::S_DOFF: begin
        phase <= !phase;
        if (phase) begin
          if (k == 3'd2) begin
            plane[3] <= psm_pkg::rsat(-(acc + pe));
            acc <= '0;
            k <= '0;
          end else begin
            acc <= acc + pe;
            k <= k + 3'd1;
          end
        end
      end
      psm_pkg::S_DOT: begin
        phase <= !phase;
        if (phase) begin
          acc <= acc + pe;
          k <= k + 3'd1;
          if (k == 3'd3) begin
            dot <= psm_pkg::rsat(acc + pe);
            col <= '0;
            row <= '0;
          end
        end
      end
      psm_pkg::S_COL: begin
        phase <= !phase;
        if (phase) begin
          rows[row] <= psm_pkg::rsat(((row == col) ? diag : '0) - pe);
          row <= row + 2'd1;
        end
      end
      psm_pkg::S_EMIT: begin
        if (emit) begin
          col <= col + 2'd1;
          row <= '0;
          phase <= 1'b0;
        end
      end
      default: begin
        k <= '0;
      end
    endcase
  end

endmodule

### rtl/planar_shadow_matrix.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      p0_x..p2_z, nine signed Q16.16 words
// out      output     out_valid / out_ready    column, m_row0..m_row3, last
// cfg      input      cfg_we                   cfg_index, cfg_data (light_x..light_w)
//
// Each input beat yields four output beats, one per matrix column, column 3 marked by last.
// One item occupies the shared 32x32 multiplier and the sequencer for its whole computation:
// the normalizing shift, the square root and three 17-step divisions dominate. A two-entry
// queue lets the input take new beats while the back end is busy.
// Reset is synchronous; it empties the queue, idles the sequencer and loads the light defaults.
// A stalled output holds its beat in the output register while the back end waits.
module planar_shadow_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] p0_x,
  input  logic signed [31:0] p0_y,
  input  logic signed [31:0] p0_z,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p1_z,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] p2_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        column,
  output logic signed [31:0] m_row0,
  output logic signed [31:0] m_row1,
  output logic signed [31:0] m_row2,
  output logic signed [31:0] m_row3,
  output logic              last,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic signed [31:0] light_x;
  logic signed [31:0] light_y;
  logic signed [31:0] light_z;
  logic signed [31:0] light_w;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  psm_pkg::item_t q_wr_item;
  psm_pkg::item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= psm_pkg::LIGHT_X_RST;
      light_y <= psm_pkg::LIGHT_Y_RST;
      light_z <= psm_pkg::LIGHT_Z_RST;
      light_w <= psm_pkg::LIGHT_W_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(psm_pkg::REG_LIGHT_X): light_x <= cfg_data;
        2'(psm_pkg::REG_LIGHT_Y): light_y <= cfg_data;
        2'(psm_pkg::REG_LIGHT_Z): light_z <= cfg_data;
        default: light_w <= cfg_data;
      endcase
    end
  end

  psm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .p0_x     (p0_x),
    .p0_y     (p0_y),
    .p0_z     (p0_z),
    .p1_x     (p1_x),
    .p1_y     (p1_y),
    .p1_z     (p1_z),
    .p2_x     (p2_x),
    .p2_y     (p2_y),
    .p2_z     (p2_z),
    .q_full   (q_full),
    .push     (q_push),
    .item     (q_wr_item)
  );

  psm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  psm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .light_x   (light_x),
    .light_y   (light_y),
    .light_z   (light_z),
    .light_w   (light_w),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .column    (column),
    .m_row0    (m_row0),
    .m_row1    (m_row1),
    .m_row2    (m_row2),
    .m_row3    (m_row3),
    .last      (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (column == 2'd3)))
    else $error("last does not match the final column");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
